>>> hw/rtl/variable_record_ring_queue_top_defines.svh
// ---------------------------------------------------------------------------
// Variable record ring queue assertion macros
// Concurrent assertion wrappers used by the file that checks the queue.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_RING_QUEUE_TOP_DEFINES_SVH
`define VARIABLE_RECORD_RING_QUEUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VRRQ_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VRRQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRRQ_ASSERT(name, clk, rst, prop, msg)
`define VRRQ_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> hw/rtl/vrrq_pkg.sv
// ---------------------------------------------------------------------------
// Variable record ring queue package
// Field widths, command and status codes, controller states and the
// result beat type.
// ---------------------------------------------------------------------------
package vrrq_pkg;

  localparam int ACT_W  = 3;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_BEGIN   = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_DEQUEUE = 3'd2,
    ACT_PEEK    = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_NO_REC = 3'd3,
    STAT_BUSY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_WR,
    ST_HDR_RD,
    ST_ZERO,
    ST_STREAM
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic [LEN_W-1:0]    stored_length;
  } result_t;

endpackage

>>> hw/rtl/vrrq_if.sv
// ---------------------------------------------------------------------------
// Variable record ring queue channels
// Command and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface vrrq_in_if;
  logic                        valid;
  logic                        ready;
  logic [vrrq_pkg::ACT_W-1:0]  action;
  logic [vrrq_pkg::LEN_W-1:0]  length;
  logic [vrrq_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output length, output data_byte,
                  input ready);
  modport sink (input valid, input action, input length, input data_byte,
                output ready);
endinterface

interface vrrq_out_if;
  logic                        valid;
  logic                        ready;
  logic [vrrq_pkg::STAT_W-1:0] status;
  logic [vrrq_pkg::BYTE_W-1:0] out_byte;
  logic                        byte_valid;
  logic                        last;
  logic [vrrq_pkg::LEN_W-1:0]  stored_length;

  modport source (output valid, output status, output out_byte, output byte_valid,
                  output last, output stored_length, input ready);
  modport sink (input valid, input status, input out_byte, input byte_valid,
                input last, input stored_length, output ready);
endinterface

>>> hw/rtl/vrrq_ram.sv
// ---------------------------------------------------------------------------
// Variable record ring queue byte memory
// Single-port synchronous RAM; read data is registered and holds until the
// next read.
// ---------------------------------------------------------------------------
module vrrq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [AW-1:0]               addr,
  input  logic [vrrq_pkg::BYTE_W-1:0] wdata,
  output logic [vrrq_pkg::BYTE_W-1:0] rdata
);

  logic [vrrq_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hw/rtl/vrrq_out_reg.sv
// ---------------------------------------------------------------------------
// Variable record ring queue output register
// Holds one result beat until the receiver takes it.
// ---------------------------------------------------------------------------
module vrrq_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  vrrq_pkg::result_t beat,
  output logic              free,
  vrrq_out_if.source        rsp
);

  logic              valid;
  vrrq_pkg::result_t held;

  assign free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= beat;
    end
  end

  assign rsp.valid         = valid;
  assign rsp.status        = held.status;
  assign rsp.out_byte      = held.out_byte;
  assign rsp.byte_valid    = held.byte_valid;
  assign rsp.last          = held.last;
  assign rsp.stored_length = held.stored_length;

endmodule

>>> hw/rtl/variable_record_ring_queue_top.sv
// ---------------------------------------------------------------------------
// Variable record ring queue
// Byte ring of length-prefixed records with begin, data, dequeue, peek and
// clear commands.
// ---------------------------------------------------------------------------
// Commands arrive on cmd and results leave on rsp, both valid/ready; a beat
// moves when valid and ready are both high.
// Begin, data, clear and refused commands give one status beat, loaded
// into the output register as the command beat is taken.
// A data beat and a clear finish as they are taken; a begin writes
// HEADER_BYTES header bytes, one per cycle through the single RAM port.
// A dequeue or peek reads the header byte, then streams up to the requested
// length of record bytes at one per cycle while rsp is ready, or gives one
// beat with byte_valid low if no bytes are returned.
// Commands are taken one at a time; the next waits until the current one's
// header writes are done and its last beat is in the output register.
// When the receiver stalls, the output register holds its beat and the RAM
// read data holds the next byte, so no read is lost or repeated.
// Reset empties the ring and drops any open record; ring contents are not
// cleared and are never read before being written.
// ---------------------------------------------------------------------------
`include "variable_record_ring_queue_top_defines.svh"

module variable_record_ring_queue_top #(
  parameter int RING_BYTES   = 1024,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_RECORD   = 64
) (
  input  logic        clk,
  input  logic        rst,
  vrrq_in_if.sink     cmd,
  vrrq_out_if.source  rsp
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int FW = $clog2(RING_BYTES + 1);
  localparam int SW = ((AW > vrrq_pkg::LEN_W) ? AW : vrrq_pkg::LEN_W) + 2;
  localparam int CW = ((FW > vrrq_pkg::BYTE_W) ? FW : vrrq_pkg::BYTE_W) + 1;
  localparam int HW = $clog2(HEADER_BYTES + 1);
  localparam int WN = vrrq_pkg::LEN_W + 1;

  localparam logic [SW-1:0] RING_SW = SW'(RING_BYTES);
  localparam logic [FW-1:0] RING_FW = FW'(RING_BYTES);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [WN-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= RING_SW) begin
      s = s - RING_SW;
    end
    return s[AW-1:0];
  endfunction

  vrrq_pkg::state_t  state, state_next;
  vrrq_pkg::action_t act;

  logic [AW-1:0]                 head, tail, rd_ptr;
  logic [FW-1:0]                 free_cnt;
  logic [vrrq_pkg::LEN_W-1:0]    pending, req_len, stored, rem_rd, rem_out;
  logic [HW-1:0]                 hdr_cnt;
  logic                          is_deq, rd_pend;

  logic                          mem_en, mem_we;
  logic [AW-1:0]                 mem_addr;
  logic [vrrq_pkg::BYTE_W-1:0]   mem_wdata, mem_rdata;

  logic                          slot_free, load, cmd_ready, acc;
  vrrq_pkg::result_t             beat;

  logic [CW-1:0]                 begin_total;
  logic                          too_long, no_room, ring_empty, begin_ok, read_ok;
  logic [vrrq_pkg::LEN_W-1:0]    hdr_stored, n_min, n_cnt;
  logic [WN-1:0]                 rec_total;
  logic [FW-1:0]                 used, free_after;
  logic [CW-1:0]                 free_sum;
  logic                          issue, consume;

  vrrq_ram #(.DEPTH(RING_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  vrrq_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .beat (beat),
    .free (slot_free),
    .rsp  (rsp)
  );

  assign act       = vrrq_pkg::action_t'(cmd.action);
  assign cmd.ready = cmd_ready;
  assign acc       = cmd.valid && cmd_ready;

  assign begin_total = CW'(cmd.length) + CW'(HEADER_BYTES);
  assign too_long    = cmd.length > vrrq_pkg::LEN_W'(MAX_RECORD);
  assign no_room     = begin_total > CW'(free_cnt);
  assign ring_empty  = free_cnt >= RING_FW;
  assign begin_ok    = (pending == '0) && !too_long && !no_room;
  assign read_ok     = (pending == '0) && !ring_empty;

  assign hdr_stored = mem_rdata[vrrq_pkg::LEN_W-1:0];
  assign n_min      = (req_len < hdr_stored) ? req_len : hdr_stored;
  assign n_cnt      = (n_min > vrrq_pkg::LEN_W'(MAX_RECORD)) ?
                      vrrq_pkg::LEN_W'(MAX_RECORD) : n_min;
  assign rec_total  = WN'(hdr_stored) + WN'(HEADER_BYTES);
  assign used       = RING_FW - free_cnt;
  assign free_sum   = CW'(free_cnt) + CW'(rec_total);
  assign free_after = (CW'(rec_total) > CW'(used)) ? RING_FW : free_sum[FW-1:0];

  assign issue   = (state == vrrq_pkg::ST_STREAM) && (rem_rd != '0) &&
                   (!rd_pend || slot_free);
  assign consume = (state == vrrq_pkg::ST_STREAM) && rd_pend && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      vrrq_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (act)
            vrrq_pkg::ACT_BEGIN: begin
              if (begin_ok && (HEADER_BYTES > 1)) begin
                state_next = vrrq_pkg::ST_HDR_WR;
              end
            end
            vrrq_pkg::ACT_DEQUEUE, vrrq_pkg::ACT_PEEK: begin
              if (read_ok) begin
                state_next = vrrq_pkg::ST_HDR_RD;
              end
            end
            default: ;
          endcase
        end
      end
      vrrq_pkg::ST_HDR_WR: begin
        if (hdr_cnt == HW'(1)) begin
          state_next = vrrq_pkg::ST_IDLE;
        end
      end
      vrrq_pkg::ST_HDR_RD: begin
        state_next = (n_cnt == '0) ? vrrq_pkg::ST_ZERO : vrrq_pkg::ST_STREAM;
      end
      vrrq_pkg::ST_ZERO: begin
        if (slot_free) begin
          state_next = vrrq_pkg::ST_IDLE;
        end
      end
      vrrq_pkg::ST_STREAM: begin
        if (consume && (rem_out == vrrq_pkg::LEN_W'(1))) begin
          state_next = vrrq_pkg::ST_IDLE;
        end
      end
      default: state_next = vrrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = tail;
    mem_wdata = '0;
    load      = 1'b0;
    beat      = '0;
    beat.last = 1'b1;
    unique case (state)
      vrrq_pkg::ST_IDLE: begin
        cmd_ready = slot_free;
        if (acc) begin
          unique case (act)
            vrrq_pkg::ACT_BEGIN: begin
              load = 1'b1;
              if (pending != '0) begin
                beat.status = vrrq_pkg::STAT_BUSY;
              end else if (too_long || no_room) begin
                beat.status = vrrq_pkg::STAT_FULL;
              end else begin
                beat.status = vrrq_pkg::STAT_OK;
                mem_en      = 1'b1;
                mem_we      = 1'b1;
                mem_wdata   = vrrq_pkg::BYTE_W'(cmd.length);
              end
            end
            vrrq_pkg::ACT_DATA: begin
              load = 1'b1;
              if (pending == '0) begin
                beat.status = vrrq_pkg::STAT_NO_REC;
              end else begin
                beat.status = vrrq_pkg::STAT_OK;
                mem_en      = 1'b1;
                mem_we      = 1'b1;
                mem_wdata   = cmd.data_byte;
              end
            end
            vrrq_pkg::ACT_DEQUEUE, vrrq_pkg::ACT_PEEK: begin
              if (pending != '0) begin
                load        = 1'b1;
                beat.status = vrrq_pkg::STAT_BUSY;
              end else if (ring_empty) begin
                load        = 1'b1;
                beat.status = vrrq_pkg::STAT_EMPTY;
              end else begin
                mem_en   = 1'b1;
                mem_addr = head;
              end
            end
            vrrq_pkg::ACT_CLEAR: begin
              load        = 1'b1;
              beat.status = vrrq_pkg::STAT_OK;
            end
            default: ;
          endcase
        end
      end
      vrrq_pkg::ST_HDR_WR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end
      vrrq_pkg::ST_HDR_RD: ;
      vrrq_pkg::ST_ZERO: begin
        load               = slot_free;
        beat.status        = vrrq_pkg::STAT_OK;
        beat.stored_length = stored;
      end
      vrrq_pkg::ST_STREAM: begin
        load               = consume;
        beat.status        = vrrq_pkg::STAT_OK;
        beat.out_byte      = mem_rdata;
        beat.byte_valid    = 1'b1;
        beat.last          = rem_out == vrrq_pkg::LEN_W'(1);
        beat.stored_length = stored;
        if (issue) begin
          mem_en   = 1'b1;
          mem_addr = rd_ptr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vrrq_pkg::ST_IDLE;
      head     <= '0;
      tail     <= '0;
      free_cnt <= RING_FW;
      pending  <= '0;
      hdr_cnt  <= '0;
      rd_pend  <= 1'b0;
      rem_rd   <= '0;
      rem_out  <= '0;
      is_deq   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        vrrq_pkg::ST_IDLE: begin
          if (acc) begin
            unique case (act)
              vrrq_pkg::ACT_BEGIN: begin
                if (begin_ok) begin
                  tail     <= wrap_add(tail, WN'(1));
                  free_cnt <= free_cnt - begin_total[FW-1:0];
                  pending  <= cmd.length;
                  hdr_cnt  <= HW'(HEADER_BYTES - 1);
                end
              end
              vrrq_pkg::ACT_DATA: begin
                if (pending != '0) begin
                  tail    <= wrap_add(tail, WN'(1));
                  pending <= pending - vrrq_pkg::LEN_W'(1);
                end
              end
              vrrq_pkg::ACT_DEQUEUE, vrrq_pkg::ACT_PEEK: begin
                is_deq <= act == vrrq_pkg::ACT_DEQUEUE;
              end
              vrrq_pkg::ACT_CLEAR: begin
                free_cnt <= RING_FW;
                head     <= tail;
                pending  <= '0;
              end
              default: ;
            endcase
          end
        end
        vrrq_pkg::ST_HDR_WR: begin
          tail    <= wrap_add(tail, WN'(1));
          hdr_cnt <= hdr_cnt - HW'(1);
        end
        vrrq_pkg::ST_HDR_RD: begin
          rem_rd  <= n_cnt;
          rem_out <= n_cnt;
          rd_pend <= 1'b0;
          if (is_deq) begin
            head     <= wrap_add(head, rec_total);
            free_cnt <= free_after;
          end
        end
        vrrq_pkg::ST_STREAM: begin
          if (issue) begin
            rem_rd <= rem_rd - vrrq_pkg::LEN_W'(1);
          end
          if (consume) begin
            rem_out <= rem_out - vrrq_pkg::LEN_W'(1);
          end
          rd_pend <= issue || (rd_pend && !consume);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == vrrq_pkg::ST_IDLE) begin
      req_len <= cmd.length;
    end
    if (state == vrrq_pkg::ST_HDR_RD) begin
      stored <= hdr_stored;
      rd_ptr <= wrap_add(head, WN'(HEADER_BYTES));
    end else if (issue) begin
      rd_ptr <= wrap_add(rd_ptr, WN'(1));
    end
  end

  `VRRQ_ASSERT(a_stall_holds_rdata, clk, rst, (state == vrrq_pkg::ST_STREAM && rd_pend && !slot_free) |=> $stable(mem_rdata), "RAM read data changed under a stalled beat")
  `VRRQ_ASSERT(a_stream_counts, clk, rst, (state == vrrq_pkg::ST_STREAM) |-> (rem_out == rem_rd + vrrq_pkg::LEN_W'(rd_pend) && rem_out != '0), "Stream read and emit counters disagree")
  `VRRQ_ASSERT_ALWAYS(a_free_bound, clk, (!rst) |=> (free_cnt <= RING_FW), "Free byte count exceeds ring size")

endmodule
